@@ rtl/polyline_perpendicular_offset_assert.svh @@
// ---------------------------------------------------------------------------
// polyline_perpendicular_offset_assert
// Assertion macros for the polyline offset block.
// ---------------------------------------------------------------------------
`ifndef POLYLINE_PERPENDICULAR_OFFSET_ASSERT_SVH
`define POLYLINE_PERPENDICULAR_OFFSET_ASSERT_SVH

// same-cycle implication
`define PPO_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PPO_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/ppo_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ppo_pkg
// Shared types and constants of the polyline perpendicular offset block.
// ---------------------------------------------------------------------------
package ppo_pkg;

   localparam int CSR_AW = 1;
   localparam int CSR_DW = 31;

   localparam logic [CSR_AW-1:0] REG_ROAD_WIDTH = 1'b0;
   localparam logic [CSR_AW-1:0] REG_AXIS_TOL   = 1'b1;

   localparam logic [30:0] ROAD_WIDTH_RST = 31'd65536;
   localparam logic [30:0] AXIS_TOL_RST   = 31'd66;

   localparam logic [1:0] OP_MUL  = 2'd0;
   localparam logic [1:0] OP_SQRT = 2'd1;
   localparam logic [1:0] OP_DIV  = 2'd2;

   localparam logic signed [33:0] SAT_MAX = 34'sh0_7FFF_FFFF;
   localparam logic signed [33:0] SAT_MIN = -34'sh0_8000_0000;

   typedef struct packed {
      logic        start;
      logic [1:0]  op;
      logic [63:0] a;
      logic [31:0] b;
   } ppo_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] value;
   } ppo_res_type;

   function automatic logic [31:0] sat32(input logic signed [33:0] v);
      logic [31:0] r;
      if (v > SAT_MAX) begin
         r = 32'h7FFF_FFFF;
      end else if (v < SAT_MIN) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ rtl/ppo_ifaces.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ppo_ifaces
// Point and margin-pair channels, valid/ready.
// ---------------------------------------------------------------------------
interface ppo_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] point_x;
   logic [31:0] point_z;
   logic        end_of_track;
   modport source (output valid, point_x, point_z, end_of_track, input ready);
   modport sink   (input valid, point_x, point_z, end_of_track, output ready);
endinterface

interface ppo_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] first_x;
   logic [31:0] first_z;
   logic [31:0] second_x;
   logic [31:0] second_z;
   logic        was_swapped;
   logic        degenerate;
   logic        last_of_run;
   modport source (output valid, first_x, first_z, second_x, second_z, was_swapped,
                   degenerate, last_of_run, input ready);
   modport sink   (input valid, first_x, first_z, second_x, second_z, was_swapped,
                   degenerate, last_of_run, output ready);
endinterface
`default_nettype wire

@@ rtl/ppo_arith.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ppo_arith
// Shared unit: registered 32x32 multiply, bit-serial square root and divide.
// ---------------------------------------------------------------------------
module ppo_arith
   import ppo_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  ppo_cmd_type cmd,
   output ppo_res_type res
);

   logic        busy_ff, busy_in;
   logic [1:0]  op_ff, op_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] acc_ff, acc_in;
   logic [34:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [31:0] div_ff, div_in;
   logic        done_ff, done_in;
   logic [63:0] val_ff, val_in;

   logic [63:0] prod;
   logic [34:0] sq_t;
   logic [34:0] sq_trial;
   logic [32:0] dv_t;

   assign prod     = cmd.a[31:0] * cmd.b;
   assign sq_t     = {rem_ff[32:0], acc_ff[63:62]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign dv_t     = {rem_ff[31:0], acc_ff[63]};

   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      div_in  = div_ff;
      done_in = 1'b0;
      val_in  = val_ff;
      if (cmd.start) begin
         op_in = cmd.op;
         case (cmd.op)
            OP_MUL: begin
               val_in  = prod;
               done_in = 1'b1;
            end
            OP_SQRT: begin
               busy_in = 1'b1;
               cnt_in  = 6'd32;
               acc_in  = cmd.a;
               rem_in  = '0;
               root_in = '0;
            end
            OP_DIV: begin
               // quotient fits 31 bits, so the upper dividend part is below the divisor
               busy_in = 1'b1;
               cnt_in  = 6'd31;
               rem_in  = {4'b0, cmd.a[61:31]};
               acc_in  = {cmd.a[30:0], 33'b0};
               root_in = '0;
               div_in  = cmd.b;
            end
            default: begin
            end
         endcase
      end else if (busy_ff) begin
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            val_in  = {32'b0, root_ff};
         end else begin
            cnt_in = cnt_ff - 6'd1;
            case (op_ff)
               OP_SQRT: begin
                  if (sq_t >= sq_trial) begin
                     rem_in  = sq_t - sq_trial;
                     root_in = {root_ff[30:0], 1'b1};
                  end else begin
                     rem_in  = sq_t;
                     root_in = {root_ff[30:0], 1'b0};
                  end
                  acc_in = {acc_ff[61:0], 2'b0};
               end
               OP_DIV: begin
                  if (dv_t >= {1'b0, div_ff}) begin
                     rem_in  = {2'b0, dv_t - {1'b0, div_ff}};
                     root_in = {root_ff[30:0], 1'b1};
                  end else begin
                     rem_in  = {2'b0, dv_t};
                     root_in = {root_ff[30:0], 1'b0};
                  end
                  acc_in = {acc_ff[62:0], 1'b0};
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff   <= op_in;
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      div_ff  <= div_in;
      val_ff  <= val_in;
   end

   assign res.done  = done_ff;
   assign res.value = val_ff;

endmodule
`default_nettype wire

@@ rtl/polyline_perpendicular_offset.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// polyline_perpendicular_offset
// Margin pairs along the segment normal for a stream of polyline points.
// ---------------------------------------------------------------------------
//  channel | dir | beat
//  req_ch  | in  | point_x, point_z, end_of_track
//  rsp_ch  | out | first_x/z, second_x/z, was_swapped, degenerate, last_of_run
//  csr     | in  | csr_we, csr_addr, csr_wdata
//
// After a point is taken, an axis segment goes from the setup step straight to
// the swap test step; a sloped one first runs the squares, the bit-serial root
// and two divides in the shared unit. The swap test uses the shared unit once
// the run has a pair. An end point makes two pairs, or one if it opens the run.
// Reset is synchronous; no memory sweep. A held result stalls the sequencer at
// the output step; req_ch is ready only between points.
// ---------------------------------------------------------------------------
`include "polyline_perpendicular_offset_assert.svh"

module polyline_perpendicular_offset
   import ppo_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  logic              clock,
   input  logic              reset,
   ppo_req_if.sink           req_ch,
   ppo_rsp_if.source         rsp_ch,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_wdata
);

   localparam logic signed [33:0] PROBE_POS = 34'sd10 <<< FRAC_BITS;
   localparam logic signed [33:0] PROBE_NEG = -PROBE_POS;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SETUP  = 4'd1;
   localparam logic [3:0] S_SQX    = 4'd2;
   localparam logic [3:0] S_SQXW   = 4'd3;
   localparam logic [3:0] S_SQZW   = 4'd4;
   localparam logic [3:0] S_ROOTW  = 4'd5;
   localparam logic [3:0] S_MULZW  = 4'd6;
   localparam logic [3:0] S_DIVXW  = 4'd7;
   localparam logic [3:0] S_MULXW  = 4'd8;
   localparam logic [3:0] S_DIVZW  = 4'd9;
   localparam logic [3:0] S_SLOPE  = 4'd10;
   localparam logic [3:0] S_CMP    = 4'd11;
   localparam logic [3:0] S_CMPW   = 4'd12;
   localparam logic [3:0] S_OUT    = 4'd13;

   logic [3:0]  state_ff, state_in;
   logic [30:0] road_width_ff, road_width_in;
   logic [30:0] axis_tol_ff, axis_tol_in;
   logic [31:0] prev_x_ff, prev_x_in, prev_z_ff, prev_z_in;
   logic [31:0] cur_x_ff, cur_x_in, cur_z_ff, cur_z_in;
   logic        end_ff, end_in;
   logic        pt_cur_ff, pt_cur_in;
   logic        last_ff, last_in;
   logic        second_ff, second_in;
   logic        have_prev_ff, have_prev_in;
   logic        have_prev_pair_ff, have_prev_pair_in;
   logic [30:0] sadx_ff, sadx_in, sadz_ff, sadz_in;
   logic        neg_t_ff, neg_t_in;
   logic [63:0] sum_ff, sum_in;
   logic [31:0] len_ff, len_in;
   logic [30:0] ox_ff, ox_in, oz_ff, oz_in;
   logic [3:0][31:0] c_ff, c_in;
   logic        deg_ff, deg_in;
   logic [1:0]  cidx_ff, cidx_in;
   logic [64:0] dist1_ff, dist1_in, dist2_ff, dist2_in;
   logic [3:0][31:0] lp_ff, lp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0][31:0] out_c_ff, out_c_in;
   logic        out_sw_ff, out_sw_in;
   logic        out_deg_ff, out_deg_in;
   logic        out_last_ff, out_last_in;

   ppo_cmd_type cmd;
   ppo_res_type ares;

   logic [31:0]        px, pz;
   logic signed [33:0] pxe, pze, w34;
   logic signed [32:0] dx, dz;
   logic [32:0]        adx_w, adz_w;
   logic [31:0]        adx, adz;
   logic               zax, xax, big;
   logic signed [33:0] ox34, oz34;
   logic [1:0]         cmp_sel;
   logic signed [32:0] cdiff;
   logic [32:0]        cabs_w;
   logic [31:0]        cabs;
   logic               swap_now;
   logic               out_load;
   logic               accept;
   logic               wait_step;

   ppo_arith u_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .res   (ares)
   );

   assign accept = req_ch.valid && (state_ff == S_IDLE);

   assign px  = pt_cur_ff ? cur_x_ff : prev_x_ff;
   assign pz  = pt_cur_ff ? cur_z_ff : prev_z_ff;
   assign pxe = {{2{px[31]}}, px};
   assign pze = {{2{pz[31]}}, pz};
   assign w34 = {3'b0, road_width_ff};

   assign dx    = $signed({cur_x_ff[31], cur_x_ff}) - $signed({prev_x_ff[31], prev_x_ff});
   assign dz    = $signed({cur_z_ff[31], cur_z_ff}) - $signed({prev_z_ff[31], prev_z_ff});
   assign adx_w = dx[32] ? 33'(-dx) : 33'(dx);
   assign adz_w = dz[32] ? 33'(-dz) : 33'(dz);
   assign adx   = adx_w[31:0];
   assign adz   = adz_w[31:0];
   assign zax   = (adz == 32'd0) || (adz < {1'b0, axis_tol_ff});
   assign xax   = (adx == 32'd0) || (adx < {1'b0, axis_tol_ff});
   assign big   = adx[31] | adz[31];

   assign ox34 = {3'b0, ox_ff};
   assign oz34 = {3'b0, oz_ff};

   assign cmp_sel  = (state_ff == S_CMP) ? 2'd0 : cidx_ff + 2'd1;
   assign cdiff    = $signed({c_ff[{1'b0, cmp_sel[0]}][31], c_ff[{1'b0, cmp_sel[0]}]})
                   - $signed({lp_ff[cmp_sel][31], lp_ff[cmp_sel]});
   assign cabs_w   = cdiff[32] ? 33'(-cdiff) : 33'(cdiff);
   assign cabs     = cabs_w[31:0];
   assign swap_now = have_prev_pair_ff && (dist1_ff > dist2_ff);
   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ch.ready);

   assign wait_step = (state_ff == S_SQXW) || (state_ff == S_SQZW) || (state_ff == S_ROOTW)
                   || (state_ff == S_MULZW) || (state_ff == S_DIVXW) || (state_ff == S_MULXW)
                   || (state_ff == S_DIVZW) || (state_ff == S_CMPW);

   always_comb begin
      cmd.start = 1'b0;
      cmd.op    = OP_MUL;
      cmd.a     = '0;
      cmd.b     = '0;
      case (state_ff)
         S_SQX: begin
            cmd.start = 1'b1;
            cmd.a     = {33'b0, sadx_ff};
            cmd.b     = {1'b0, sadx_ff};
         end
         S_SQXW: begin
            cmd.start = ares.done;
            cmd.a     = {33'b0, sadz_ff};
            cmd.b     = {1'b0, sadz_ff};
         end
         S_SQZW: begin
            cmd.start = ares.done;
            cmd.op    = OP_SQRT;
            cmd.a     = sum_ff + ares.value;
         end
         S_ROOTW: begin
            cmd.start = ares.done;
            cmd.a     = {33'b0, road_width_ff};
            cmd.b     = {1'b0, sadz_ff};
         end
         S_MULZW, S_MULXW: begin
            cmd.start = ares.done;
            cmd.op    = OP_DIV;
            cmd.a     = ares.value;
            cmd.b     = len_ff;
         end
         S_DIVXW: begin
            cmd.start = ares.done;
            cmd.a     = {33'b0, road_width_ff};
            cmd.b     = {1'b0, sadx_ff};
         end
         S_CMP: begin
            cmd.start = have_prev_pair_ff;
            cmd.a     = {32'b0, cabs};
            cmd.b     = cabs;
         end
         S_CMPW: begin
            cmd.start = ares.done && (cidx_ff != 2'd3);
            cmd.a     = {32'b0, cabs};
            cmd.b     = cabs;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in          = state_ff;
      road_width_in     = road_width_ff;
      axis_tol_in       = axis_tol_ff;
      prev_x_in         = prev_x_ff;
      prev_z_in         = prev_z_ff;
      cur_x_in          = cur_x_ff;
      cur_z_in          = cur_z_ff;
      end_in            = end_ff;
      pt_cur_in         = pt_cur_ff;
      last_in           = last_ff;
      second_in         = second_ff;
      have_prev_in      = have_prev_ff;
      have_prev_pair_in = have_prev_pair_ff;
      sadx_in           = sadx_ff;
      sadz_in           = sadz_ff;
      neg_t_in          = neg_t_ff;
      sum_in            = sum_ff;
      len_in            = len_ff;
      ox_in             = ox_ff;
      oz_in             = oz_ff;
      c_in              = c_ff;
      deg_in            = deg_ff;
      cidx_in           = cidx_ff;
      dist1_in          = dist1_ff;
      dist2_in          = dist2_ff;
      lp_in             = lp_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ch.ready;
      out_c_in          = out_c_ff;
      out_sw_in         = out_sw_ff;
      out_deg_in        = out_deg_ff;
      out_last_in       = out_last_ff;

      if (csr_we) begin
         case (csr_addr)
            REG_ROAD_WIDTH: road_width_in = csr_wdata;
            REG_AXIS_TOL:   axis_tol_in   = csr_wdata;
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cur_x_in = req_ch.point_x;
               cur_z_in = req_ch.point_z;
               end_in   = req_ch.end_of_track;
               if (!have_prev_ff) begin
                  prev_x_in = req_ch.point_x;
                  prev_z_in = req_ch.point_z;
                  if (!req_ch.end_of_track) begin
                     have_prev_in = 1'b1;
                  end else begin
                     pt_cur_in = 1'b1;
                     last_in   = 1'b1;
                     second_in = 1'b0;
                     state_in  = S_SETUP;
                  end
               end else begin
                  pt_cur_in = 1'b0;
                  last_in   = 1'b0;
                  second_in = req_ch.end_of_track;
                  state_in  = S_SETUP;
               end
            end
         end
         S_SETUP: begin
            deg_in   = 1'b0;
            sadx_in  = big ? adx[31:1] : adx[30:0];
            sadz_in  = big ? adz[31:1] : adz[30:0];
            neg_t_in = dx[32] ^ dz[32];
            if (zax) begin
               c_in[0]  = px;
               c_in[1]  = sat32(pze + w34);
               c_in[2]  = px;
               c_in[3]  = sat32(pze - w34);
               state_in = S_CMP;
            end else if (xax) begin
               c_in[0]  = sat32(pxe + w34);
               c_in[1]  = pz;
               c_in[2]  = sat32(pxe - w34);
               c_in[3]  = pz;
               state_in = S_CMP;
            end else begin
               state_in = S_SQX;
            end
         end
         S_SQX: begin
            state_in = S_SQXW;
         end
         S_SQXW: begin
            if (ares.done) begin
               sum_in   = ares.value;
               state_in = S_SQZW;
            end
         end
         S_SQZW: begin
            if (ares.done) begin
               state_in = S_ROOTW;
            end
         end
         S_ROOTW: begin
            if (ares.done) begin
               len_in   = ares.value[31:0];
               state_in = S_MULZW;
            end
         end
         S_MULZW: begin
            if (ares.done) begin
               state_in = S_DIVXW;
            end
         end
         S_DIVXW: begin
            if (ares.done) begin
               ox_in    = ares.value[30:0];
               state_in = S_MULXW;
            end
         end
         S_MULXW: begin
            if (ares.done) begin
               state_in = S_DIVZW;
            end
         end
         S_DIVZW: begin
            if (ares.done) begin
               oz_in    = ares.value[30:0];
               state_in = S_SLOPE;
            end
         end
         S_SLOPE: begin
            // probe at -10 gives the first point, +10 the second
            if (PROBE_NEG == pxe) begin
               c_in[0] = px;
               c_in[1] = pz;
               deg_in  = 1'b1;
            end else begin
               c_in[0] = (PROBE_NEG > pxe) ? sat32(pxe + ox34) : sat32(pxe - ox34);
               c_in[1] = ((PROBE_NEG > pxe) ^ neg_t_ff) ? sat32(pze - oz34)
                                                       : sat32(pze + oz34);
            end
            if (PROBE_POS == pxe) begin
               c_in[2] = px;
               c_in[3] = pz;
               deg_in  = 1'b1;
            end else begin
               c_in[2] = (PROBE_POS > pxe) ? sat32(pxe + ox34) : sat32(pxe - ox34);
               c_in[3] = ((PROBE_POS > pxe) ^ neg_t_ff) ? sat32(pze - oz34)
                                                       : sat32(pze + oz34);
            end
            state_in = S_CMP;
         end
         S_CMP: begin
            cidx_in  = 2'd0;
            dist1_in = '0;
            dist2_in = '0;
            state_in = have_prev_pair_ff ? S_CMPW : S_OUT;
         end
         S_CMPW: begin
            if (ares.done) begin
               if (cidx_ff[1]) begin
                  dist2_in = dist2_ff + {1'b0, ares.value};
               end else begin
                  dist1_in = dist1_ff + {1'b0, ares.value};
               end
               cidx_in = cidx_ff + 2'd1;
               if (cidx_ff == 2'd3) begin
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               if (swap_now) begin
                  out_c_in = {c_ff[1], c_ff[0], c_ff[3], c_ff[2]};
               end else begin
                  out_c_in = c_ff;
               end
               lp_in             = out_c_in;
               out_sw_in         = swap_now;
               out_deg_in        = deg_ff;
               out_last_in       = last_ff;
               have_prev_pair_in = 1'b1;
               if (second_ff) begin
                  second_in = 1'b0;
                  pt_cur_in = 1'b1;
                  last_in   = 1'b1;
                  state_in  = S_SETUP;
               end else begin
                  prev_x_in = cur_x_ff;
                  prev_z_in = cur_z_ff;
                  if (end_ff) begin
                     have_prev_in      = 1'b0;
                     have_prev_pair_in = 1'b0;
                  end
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         road_width_ff     <= ROAD_WIDTH_RST;
         axis_tol_ff       <= AXIS_TOL_RST;
         prev_x_ff         <= '0;
         prev_z_ff         <= '0;
         have_prev_ff      <= 1'b0;
         have_prev_pair_ff <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         road_width_ff     <= road_width_in;
         axis_tol_ff       <= axis_tol_in;
         prev_x_ff         <= prev_x_in;
         prev_z_ff         <= prev_z_in;
         have_prev_ff      <= have_prev_in;
         have_prev_pair_ff <= have_prev_pair_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      cur_x_ff    <= cur_x_in;
      cur_z_ff    <= cur_z_in;
      end_ff      <= end_in;
      pt_cur_ff   <= pt_cur_in;
      last_ff     <= last_in;
      second_ff   <= second_in;
      sadx_ff     <= sadx_in;
      sadz_ff     <= sadz_in;
      neg_t_ff    <= neg_t_in;
      sum_ff      <= sum_in;
      len_ff      <= len_in;
      ox_ff       <= ox_in;
      oz_ff       <= oz_in;
      c_ff        <= c_in;
      deg_ff      <= deg_in;
      cidx_ff     <= cidx_in;
      dist1_ff    <= dist1_in;
      dist2_ff    <= dist2_in;
      lp_ff       <= lp_in;
      out_c_ff    <= out_c_in;
      out_sw_ff   <= out_sw_in;
      out_deg_ff  <= out_deg_in;
      out_last_ff <= out_last_in;
   end

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.first_x     = out_c_ff[0];
   assign rsp_ch.first_z     = out_c_ff[1];
   assign rsp_ch.second_x    = out_c_ff[2];
   assign rsp_ch.second_z    = out_c_ff[3];
   assign rsp_ch.was_swapped = out_sw_ff;
   assign rsp_ch.degenerate  = out_deg_ff;
   assign rsp_ch.last_of_run = out_last_ff;

   `PPO_ASSERT_NOW(a_pair_needs_prev, have_prev_pair_ff, have_prev_ff, "pair without point")
   `PPO_ASSERT_NOW(a_done_in_wait, ares.done, wait_step, "shared unit done outside wait")
   `PPO_ASSERT_NEXT(a_last_clears_run, out_load && last_ff, !have_prev_ff && !have_prev_pair_ff, "run kept")

endmodule
`default_nettype wire
